### sv/assert_macros.svh
// Assertion helper macros used by the checker file.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock with an active-low reset.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("concurrent assertion failed");

// Same, on the block's own clk / arst_n.
`define ASSERT_STD(label, prop) \
	`ASSERT_CLK(label, clk, arst_n, prop)

`endif

### sv/wecb_pkg.sv
// Shared types and codes for the window event count block.
// No dependencies; used by the interfaces, controller, datapath and checker.
package wecb_pkg;

	localparam int CNT_OUT_W = 11;
	localparam int STATUS_W  = 3;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_LOADED   = 3'd0,
		STS_FULL     = 3'd1,
		STS_ORDER    = 3'd2,
		STS_ANSWERED = 3'd3,
		STS_INVALID  = 3'd4
	} status_t;

	typedef struct packed {
		logic        func;
		logic [31:0] event_time;
		logic [31:0] window_length;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [CNT_OUT_W-1:0] max_count;
		logic [CNT_OUT_W-1:0] min_count;
	} rsp_word_t;

	// which sweep pointer addresses the store read port
	typedef enum logic [1:0] {
		RD_A = 2'd0,
		RD_B = 2'd1,
		RD_J = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    append;
		logic    start_query;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    inc_a;
		logic    inc_b;
		logic    inc_j;
		logic    max_init;
		logic    max_upd;
		logic    win_max;
		logic    min_init;
		logic    min_upd;
		logic    win_min;
		logic    out_load;
		status_t out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic a_lt_n;
		logic b_lt_n;
		logic j_lt_n;
		logic rd_lt_lo;
		logic rd_le_lo;
		logic rd_lt_hi;
		logic rd_le_hi;
		logic rd_lt_len;
		logic rd_gt_tmax;
		logic full;
		logic out_of_order;
		logic bad_query;
	} dp_sts_t;

endpackage

### sv/wecb_ifs.sv
// Valid/ready channel interfaces for request and response words.
// Depends on wecb_pkg.
interface wecb_req_if;
	import wecb_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wecb_rsp_if;
	import wecb_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/wecb_ctrl.sv
// Sequencer for appends and the two-pointer query sweeps.
// Depends on wecb_pkg; drives wecb_dp through dp_cmd_t / dp_sts_t.
module wecb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_func,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output wecb_pkg::dp_cmd_t cmd,
	input  wecb_pkg::dp_sts_t sts
);
	import wecb_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_MB_RD  = 19'h00002,
		S_MB_CK  = 19'h00004,
		S_MJ_RD  = 19'h00008,
		S_MJ_CK  = 19'h00010,
		S_MA_RD  = 19'h00020,
		S_MA_CK  = 19'h00040,
		S_MBB_RD = 19'h00080,
		S_MBB_CK = 19'h00100,
		S_MUP    = 19'h00200,
		S_NA_RD  = 19'h00400,
		S_NA_CK  = 19'h00800,
		S_NB_RD  = 19'h01000,
		S_NB_CK  = 19'h02000,
		S_NUP    = 19'h04000,
		S_NJ_RD  = 19'h08000,
		S_NJ_CK  = 19'h10000,
		S_DONE   = 19'h20000,
		S_SPARE  = 19'h40000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   rsp_free;
	logic   accept;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && rsp_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_func == FUNC_APPEND) begin
						cmd.out_load = 1'b1;
						if (sts.full) begin
							cmd.out_status = STS_FULL;
						end else if (sts.out_of_order) begin
							cmd.out_status = STS_ORDER;
						end else begin
							cmd.append     = 1'b1;
							cmd.out_status = STS_LOADED;
						end
					end else if (sts.bad_query) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = STS_INVALID;
					end else begin
						cmd.start_query = 1'b1;
						state_d         = S_MB_RD;
					end
				end
			end
			// max sweep: count events at or below L for t = 0
			S_MB_RD: begin
				if (sts.b_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_B;
					state_d    = S_MB_CK;
				end else begin
					cmd.max_init = 1'b1;
					state_d      = S_MJ_RD;
				end
			end
			S_MB_CK: begin
				if (sts.rd_le_hi) begin
					cmd.inc_b = 1'b1;
					state_d   = S_MB_RD;
				end else begin
					cmd.max_init = 1'b1;
					state_d      = S_MJ_RD;
				end
			end
			// max sweep: windows ending on each event at or past L
			S_MJ_RD: begin
				if (sts.j_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_J;
					state_d    = S_MJ_CK;
				end else begin
					cmd.min_init = 1'b1;
					state_d      = S_NA_RD;
				end
			end
			S_MJ_CK: begin
				if (sts.rd_lt_len) begin
					cmd.inc_j = 1'b1;
					state_d   = S_MJ_RD;
				end else begin
					cmd.win_max = 1'b1;
					state_d     = S_MA_RD;
				end
			end
			S_MA_RD: begin
				if (sts.a_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_A;
					state_d    = S_MA_CK;
				end else begin
					state_d = S_MBB_RD;
				end
			end
			S_MA_CK: begin
				if (sts.rd_lt_lo) begin
					cmd.inc_a = 1'b1;
					state_d   = S_MA_RD;
				end else begin
					state_d = S_MBB_RD;
				end
			end
			S_MBB_RD: begin
				if (sts.b_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_B;
					state_d    = S_MBB_CK;
				end else begin
					state_d = S_MUP;
				end
			end
			S_MBB_CK: begin
				if (sts.rd_le_hi) begin
					cmd.inc_b = 1'b1;
					state_d   = S_MBB_RD;
				end else begin
					state_d = S_MUP;
				end
			end
			S_MUP: begin
				cmd.max_upd = 1'b1;
				cmd.inc_j   = 1'b1;
				state_d     = S_MJ_RD;
			end
			// min sweep: open window (t, t+L) for t = 0 and t = each event up to the last timestamp minus L
			S_NA_RD: begin
				if (sts.a_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_A;
					state_d    = S_NA_CK;
				end else begin
					state_d = S_NB_RD;
				end
			end
			S_NA_CK: begin
				if (sts.rd_le_lo) begin
					cmd.inc_a = 1'b1;
					state_d   = S_NA_RD;
				end else begin
					state_d = S_NB_RD;
				end
			end
			S_NB_RD: begin
				if (sts.b_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_B;
					state_d    = S_NB_CK;
				end else begin
					state_d = S_NUP;
				end
			end
			S_NB_CK: begin
				if (sts.rd_lt_hi) begin
					cmd.inc_b = 1'b1;
					state_d   = S_NB_RD;
				end else begin
					state_d = S_NUP;
				end
			end
			S_NUP: begin
				cmd.min_upd = 1'b1;
				state_d     = sts.j_lt_n ? S_NJ_RD : S_DONE;
			end
			S_NJ_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_J;
				cmd.inc_j  = 1'b1;
				state_d    = S_NJ_CK;
			end
			S_NJ_CK: begin
				if (sts.rd_gt_tmax) begin
					state_d = S_DONE;
				end else begin
					cmd.win_min = 1'b1;
					state_d     = S_NA_RD;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = STS_ANSWERED;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/wecb_dp.sv
// Datapath: timestamp store, sweep pointers, window bounds, best counts
// and the response word register. Depends on wecb_pkg; steered by wecb_ctrl.
module wecb_dp #(
	parameter int STORE_DEPTH = 1024,
	parameter int TIME_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wecb_pkg::req_word_t req_data,
	input  wecb_pkg::dp_cmd_t   cmd,
	output wecb_pkg::dp_sts_t   sts,
	output wecb_pkg::rsp_word_t rsp_data
);
	import wecb_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int TW = TIME_BITS;

	logic [TW-1:0] mem [STORE_DEPTH];

	logic [CW-1:0] count_q;
	logic [TW-1:0] latest_q;
	logic [CW-1:0] a_q, b_q, j_q;
	logic [TW-1:0] len_q, tmax_q, lo_q, hi_q;
	logic [TW-1:0] rdata_q;
	logic [CW-1:0] best_max_q, best_min_q;
	rsp_word_t     rsp_q;

	logic [TW-1:0] ts, len_in;
	logic [AW-1:0] raddr;
	logic [CW-1:0] span, open_cnt;
	logic          b_gt_a;

	assign ts     = TW'(req_data.event_time);
	assign len_in = TW'(req_data.window_length);

	assign sts.full         = (count_q == CW'(STORE_DEPTH));
	assign sts.out_of_order = (count_q != '0) && (ts < latest_q);
	assign sts.bad_query    = (count_q == '0) || (len_in >= latest_q);
	assign sts.a_lt_n       = (a_q < count_q);
	assign sts.b_lt_n       = (b_q < count_q);
	assign sts.j_lt_n       = (j_q < count_q);
	assign sts.rd_lt_lo     = (rdata_q < lo_q);
	assign sts.rd_le_lo     = (rdata_q <= lo_q);
	assign sts.rd_lt_hi     = (rdata_q < hi_q);
	assign sts.rd_le_hi     = (rdata_q <= hi_q);
	assign sts.rd_lt_len    = (rdata_q < len_q);
	assign sts.rd_gt_tmax   = (rdata_q > tmax_q);

	// open-window count is floored at zero when b trails a
	assign b_gt_a   = (b_q > a_q);
	assign span     = b_q - a_q;
	assign open_cnt = b_gt_a ? span : '0;

	always_comb begin
		case (cmd.rd_sel)
			RD_A:    raddr = a_q[AW-1:0];
			RD_B:    raddr = b_q[AW-1:0];
			RD_J:    raddr = j_q[AW-1:0];
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[count_q[AW-1:0]] <= ts;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			latest_q <= '0;
		end else if (cmd.append) begin
			count_q  <= count_q + CW'(1);
			latest_q <= ts;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query || cmd.min_init) begin
			a_q <= '0;
			b_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.inc_a) begin
				a_q <= a_q + CW'(1);
			end
			if (cmd.inc_b) begin
				b_q <= b_q + CW'(1);
			end
			if (cmd.inc_j) begin
				j_q <= j_q + CW'(1);
			end
		end

		if (cmd.start_query) begin
			len_q  <= len_in;
			tmax_q <= latest_q - len_in;
			hi_q   <= len_in;
		end else if (cmd.min_init) begin
			lo_q <= '0;
			hi_q <= len_q;
		end else if (cmd.win_max) begin
			lo_q <= rdata_q - len_q;
			hi_q <= rdata_q;
		end else if (cmd.win_min) begin
			lo_q <= rdata_q;
			hi_q <= rdata_q + len_q;
		end

		if (cmd.max_init) begin
			best_max_q <= b_q;
		end else if (cmd.max_upd && b_gt_a && (span > best_max_q)) begin
			best_max_q <= span;
		end

		if (cmd.min_init) begin
			best_min_q <= count_q;
		end else if (cmd.min_upd && (open_cnt < best_min_q)) begin
			best_min_q <= open_cnt;
		end

		if (cmd.out_load) begin
			rsp_q.status <= cmd.out_status;
			if (cmd.out_status == STS_ANSWERED) begin
				rsp_q.max_count <= CNT_OUT_W'(best_max_q);
				rsp_q.min_count <= CNT_OUT_W'(best_min_q);
			end else begin
				rsp_q.max_count <= '0;
				rsp_q.min_count <= '0;
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

### sv/window_event_count_bounds.sv
// Top level: event timestamp store with windowed max/min count queries.
// Depends on wecb_pkg, wecb_ifs, wecb_ctrl and wecb_dp.
//
//  channel | dir | word fields                              | handshake
//  --------+-----+------------------------------------------+------------
//  req     | in  | func, event_time, window_length          | valid/ready
//  rsp     | out | status, max_count, min_count             | valid/ready
//
// Append or rejected query: response word registered the cycle after accept.
// Answered query: sweeps the store through one registered read port;
//   one word in flight.
// Reset clears the event count and last timestamp; the store is not cleared.
// req is held off while a query runs or while a response word waits on rsp.
module window_event_count_bounds #(
	parameter int STORE_DEPTH = 1024,
	parameter int TIME_BITS   = 32
) (
	input logic        clk,
	input logic        arst_n,
	wecb_req_if.sink   req,
	wecb_rsp_if.source rsp
);
	import wecb_pkg::*;

	dp_cmd_t   cmd;
	dp_sts_t   sts;
	rsp_word_t rsp_data;
	logic      req_ready;
	logic      rsp_valid;

	wecb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.data.func),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wecb_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

endmodule

### sv/wecb_checker.sv
// Port-level checks for window_event_count_bounds, bound to the top level.
// Depends on wecb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wecb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [wecb_pkg::STATUS_W-1:0]  rsp_status,
	input logic [wecb_pkg::CNT_OUT_W-1:0] rsp_max,
	input logic [wecb_pkg::CNT_OUT_W-1:0] rsp_min
);
	import wecb_pkg::*;

	// stalled response word stays up
	`ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))

	// no new word taken while a response waits
	`ASSERT_STD(a_no_accept_on_stall, rsp_valid && !rsp_ready |-> !req_ready)

	// counts only carried by answered queries
	`ASSERT_STD(a_zero_counts, rsp_valid && (rsp_status != STS_ANSWERED) |-> (rsp_max == '0) && (rsp_min == '0))

	// t = 0 is a candidate of both sweeps, so min never exceeds max
	`ASSERT_STD(a_min_le_max, rsp_valid && (rsp_status == STS_ANSWERED) |-> rsp_min <= rsp_max)

endmodule

bind window_event_count_bounds wecb_checker u_wecb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_max    (rsp.data.max_count),
	.rsp_min    (rsp.data.min_count)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for window_event_count_bounds: random and directed
// appends and window queries, predicted and checked word by word.
// Depends on wecb_pkg, wecb_ifs and the window_event_count_bounds RTL.
module testbench;
	import wecb_pkg::*;

	localparam int MAX_EV       = 1024;
	localparam int GROW_CAP     = 200;
	localparam int LIMIT_CYCLES = 5000000;

	class window_count_scoreboard;
		logic [31:0] stamps [MAX_EV];
		int unsigned stored;
		logic [31:0] last_stamp;
		rsp_word_t   awaited_words [$];
		int          mismatches;

		function new();
			stored = 0;
			last_stamp = '0;
			mismatches = 0;
		endfunction

		// closed-window max and open-window min over window starts 0 to last stamp minus len
		function void sweep_counts(input logic [31:0] len, output logic [10:0] most,
				output logic [10:0] fewest);
			int unsigned lo, hi, best, k;
			longint unsigned start, last_start;
			lo = 0;
			hi = 0;
			while (hi < stored && stamps[hi] <= len)
				hi++;
			best = hi;
			for (k = 0; k < stored; k++) begin
				if (stamps[k] < len)
					continue;
				start = stamps[k] - len;
				while (lo < stored && stamps[lo] < start)
					lo++;
				while (hi < stored && stamps[hi] <= stamps[k])
					hi++;
				if (hi - lo > best)
					best = hi - lo;
			end
			most = 11'(best);

			last_start = last_stamp - len;
			best = stored;
			lo = 0;
			hi = 0;
			for (k = 0; k <= stored; k++) begin
				if (k == 0) begin
					start = 0;
				end else begin
					start = stamps[k-1];
					if (start > last_start)
						break;
				end
				while (lo < stored && stamps[lo] <= start)
					lo++;
				while (hi < stored && stamps[hi] < start + len)
					hi++;
				if (hi <= lo)
					best = 0;
				else if (hi - lo < best)
					best = hi - lo;
			end
			fewest = 11'(best);
		endfunction

		function void note_request(input req_word_t w);
			rsp_word_t   want;
			logic [10:0] most, fewest;
			want = '0;
			if (w.func == FUNC_APPEND) begin
				if (stored >= MAX_EV) begin
					want.status = STS_FULL;
				end else if (stored > 0 && w.event_time < last_stamp) begin
					want.status = STS_ORDER;
				end else begin
					stamps[stored] = w.event_time;
					stored++;
					last_stamp = w.event_time;
					want.status = STS_LOADED;
				end
			end else if (stored == 0 || w.window_length >= last_stamp) begin
				want.status = STS_INVALID;
			end else begin
				sweep_counts(w.window_length, most, fewest);
				want.status = STS_ANSWERED;
				want.max_count = most;
				want.min_count = fewest;
			end
			awaited_words.insert(awaited_words.size(), want);
		endfunction

		function void check_response(input rsp_word_t got);
			rsp_word_t want;
			if (awaited_words.size() == 0) begin
				$error("unexpected response word: status %0d max %0d min %0d",
					got.status, got.max_count, got.min_count);
				mismatches++;
				return;
			end
			want = awaited_words.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.max_count !== want.max_count) begin
				$error("max_count: expected %0d, actual %0d", want.max_count, got.max_count);
				mismatches++;
			end
			if (got.min_count !== want.min_count) begin
				$error("min_count: expected %0d, actual %0d", want.min_count, got.min_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wecb_req_if req_ch ();
	wecb_rsp_if rsp_ch ();

	window_event_count_bounds #(
		.STORE_DEPTH(MAX_EV),
		.TIME_BITS  (32)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	window_count_scoreboard sb = new();

	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;
	int          hold_request  = 0;
	int          stall_left    = 0;
	int          cycles        = 0;
	// stimulus-side copy of the store fill, to steer in-order timestamps
	int unsigned gen_count     = 0;
	logic [31:0] gen_top       = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[window_event_count_bounds] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.data);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.data);
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_request > 0) begin
			stall_left = hold_request - 1;
			hold_request = 0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_word(input logic func, input logic [31:0] stamp,
			input logic [31:0] len);
		req_word_t w;
		w.func = func;
		w.event_time = stamp;
		w.window_length = len;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		if (func == FUNC_APPEND && gen_count < MAX_EV && (gen_count == 0 || stamp >= gen_top)) begin
			gen_count++;
			gen_top = stamp;
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		// let the monitor record the last accepted word first
		@(posedge clk);
		while (sb.awaited_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int items, input int src_pct, input int sink_pct);
		int          pick;
		logic [31:0] stamp;
		logic [31:0] len;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < 50 && gen_count < GROW_CAP) begin
				case ($urandom_range(3))
					0: stamp = gen_top;
					1: stamp = gen_top + $urandom_range(1, 3);
					2: stamp = gen_top + $urandom_range(1, 40);
					default: stamp = gen_top + $urandom_range(1, 2000);
				endcase
				send_word(FUNC_APPEND, stamp, $urandom());
			end else if (pick < 60) begin
				// gen_top is nonzero once the directed part has run
				send_word(FUNC_APPEND, $urandom_range(gen_top - 1), $urandom());
			end else if (pick < 72) begin
				send_word(FUNC_QUERY, $urandom(), $urandom());
			end else begin
				case ($urandom_range(3))
					0: len = 0;
					1: len = gen_top - 1;
					2: len = $urandom_range(gen_top / 8);
					default: len = $urandom_range(gen_top - 1);
				endcase
				send_word(FUNC_QUERY, $urandom(), len);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 6;
		sink_idle_pct = 54;
		// empty store, then duplicates, order drop, zero length and edge lengths
		send_word(FUNC_QUERY, 32'h0, 32'h0);
		send_word(FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(FUNC_APPEND, 32'd0, 32'hFFFF_FFFF);
		send_word(FUNC_QUERY, 32'h0, 32'd0);
		send_word(FUNC_APPEND, 32'd0, 32'h0);
		send_word(FUNC_APPEND, 32'd5, 32'h0);
		send_word(FUNC_APPEND, 32'd5, 32'h0);
		send_word(FUNC_APPEND, 32'd3, 32'h0);
		send_word(FUNC_APPEND, 32'd9, 32'h0);
		send_word(FUNC_QUERY, 32'h0, 32'd0);
		send_word(FUNC_QUERY, 32'h0, 32'd4);
		send_word(FUNC_QUERY, 32'h0, 32'd8);
		send_word(FUNC_QUERY, 32'h0, 32'd9);
		send_word(FUNC_QUERY, 32'h0, 32'hFFFF_FFFF);
		send_word(FUNC_APPEND, 32'd12, 32'h0);
		send_word(FUNC_APPEND, 32'd13, 32'h0);
		send_word(FUNC_APPEND, 32'd20, 32'h0);
		send_word(FUNC_QUERY, 32'h0, 32'd1);
		send_word(FUNC_QUERY, 32'h0, 32'd6);
		send_word(FUNC_QUERY, 32'h0, 32'd19);
		send_word(FUNC_QUERY, 32'h0, 32'd20);
		send_word(FUNC_APPEND, 32'd19, 32'h0);

		run_phase(90, 6, 54);
		wait_drained();
		// long receiver hold-off while words keep coming
		hold_request = 300;
		run_phase(90, 54, 6);
		wait_drained();
		run_phase(90, 0, 0);

		// closing queries on the grown store, including both length edges
		send_word(FUNC_QUERY, $urandom(), 32'd0);
		send_word(FUNC_QUERY, $urandom(), gen_top - 32'd1);
		send_word(FUNC_QUERY, $urandom(), gen_top);
		send_word(FUNC_QUERY, $urandom(), 32'hFFFF_FFFF);

		wait_drained();
		repeat (64) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[window_event_count_bounds] OK");
		else
			$display("[window_event_count_bounds] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/wecb_pkg.sv
sv/wecb_ifs.sv
sv/wecb_ctrl.sv
sv/wecb_dp.sv
sv/window_event_count_bounds.sv
sv/wecb_checker.sv
sim/testbench.sv
